[rtl/pit_pkg.sv]
// Shared constants and control types for the point-in-tetrahedron test.
package pit_pkg;

    // Width of one packed point field on the input bus
    localparam int unsigned FIELD_W     = 60;
    localparam int unsigned NUM_POINTS  = 5;
    localparam int unsigned S_TDATA_W   = ((FIELD_W * NUM_POINTS + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W   = 8;

    // Point slots in the input beat
    localparam int unsigned PT_A = 0;
    localparam int unsigned PT_B = 1;
    localparam int unsigned PT_C = 2;
    localparam int unsigned PT_D = 3;
    localparam int unsigned PT_Q = 4;

    // Edge vectors formed in the first stage
    localparam int unsigned NUM_DIFFS = 8;
    localparam int unsigned D_AB = 0;
    localparam int unsigned D_AC = 1;
    localparam int unsigned D_AD = 2;
    localparam int unsigned D_AQ = 3;
    localparam int unsigned D_BC = 4;
    localparam int unsigned D_BD = 5;
    localparam int unsigned D_BA = 6;
    localparam int unsigned D_BQ = 7;

    // Per-stage load strobes handed to each face datapath
    typedef struct packed {
        logic adv2;
        logic adv3;
    } pit_adv_t;

endpackage

[rtl/point_in_tetrahedron_test.sv]
// Top level of the point-in-tetrahedron test: edge vectors, four faces, result register.
//
//  Port group  | Dir | Beat contents
//  ------------+-----+------------------------------------------------------------
//  s_axis_*    | in  | tdata: vertex_a, vertex_b, vertex_c, vertex_d, query_point
//  m_axis_*    | out | tdata: is_inside
//
// One beat is accepted per cycle unless a held m_axis output has backed up the pipeline; its
// result is offered on m_axis after the four register stages (edges, normals, dot terms, output).
// Reset clears only the stage valid bits. Each stage loads whenever it is empty
// or the stage after it moves, so a held output still lets earlier stages fill.
module point_in_tetrahedron_test
    import pit_pkg::*;
#(
    parameter int unsigned COORD_BITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vertex_a[59:0], vertex_b[119:60], vertex_c[179:120], vertex_d[239:180],
    // query_point[299:240], zero fill [303:300]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // is_inside[0], zero fill [7:1]
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int unsigned DW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] coord [NUM_POINTS][3];
    logic signed [DW-1:0]         diff_next [NUM_DIFFS][3];
    logic signed [DW-1:0]         diff_reg  [NUM_DIFFS][3];
    logic                         v1_reg, v2_reg, v3_reg, v4_reg;
    logic                         ready1, ready2, ready3, ready4;
    logic                         inside_reg;
    logic [3:0]                   face_pass;
    pit_adv_t                     adv;

    // Stage handshake: a stage takes new data when empty or when it drains
    assign ready4 = !v4_reg || m_axis_tready;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign s_axis_tready = ready1;
    assign adv.adv2 = v1_reg && ready2;
    assign adv.adv3 = v2_reg && ready3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ready1) v1_reg <= s_axis_tvalid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
        end
    end

    // Unpack signed coordinates, x in the low bits of each field
    always_comb begin
        for (int p = 0; p < NUM_POINTS; p++) begin
            for (int k = 0; k < 3; k++) begin
                coord[p][k] = s_axis_tdata[p*FIELD_W + k*COORD_BITS +: COORD_BITS];
            end
        end
    end

    // Form the edge vectors used by the four faces
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff_next[D_AB][k] = DW'(coord[PT_B][k]) - DW'(coord[PT_A][k]);
            diff_next[D_AC][k] = DW'(coord[PT_C][k]) - DW'(coord[PT_A][k]);
            diff_next[D_AD][k] = DW'(coord[PT_D][k]) - DW'(coord[PT_A][k]);
            diff_next[D_AQ][k] = DW'(coord[PT_Q][k]) - DW'(coord[PT_A][k]);
            diff_next[D_BC][k] = DW'(coord[PT_C][k]) - DW'(coord[PT_B][k]);
            diff_next[D_BD][k] = DW'(coord[PT_D][k]) - DW'(coord[PT_B][k]);
            diff_next[D_BA][k] = DW'(coord[PT_A][k]) - DW'(coord[PT_B][k]);
            diff_next[D_BQ][k] = DW'(coord[PT_Q][k]) - DW'(coord[PT_B][k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && ready1) begin
            diff_reg <= diff_next;
        end
    end

    // Face opposite d: origin a, edges to b and c
    pit_face #(.COORD_BITS(COORD_BITS)) u_face_abc (
        .aclk    (aclk),
        .adv     (adv),
        .edge1_i (diff_reg[D_AB]),
        .edge2_i (diff_reg[D_AC]),
        .off_i   (diff_reg[D_AD]),
        .query_i (diff_reg[D_AQ]),
        .pass_o  (face_pass[0])
    );

    // Face opposite c: origin a, edges to b and d
    pit_face #(.COORD_BITS(COORD_BITS)) u_face_abd (
        .aclk    (aclk),
        .adv     (adv),
        .edge1_i (diff_reg[D_AB]),
        .edge2_i (diff_reg[D_AD]),
        .off_i   (diff_reg[D_AC]),
        .query_i (diff_reg[D_AQ]),
        .pass_o  (face_pass[1])
    );

    // Face opposite b: origin a, edges to c and d
    pit_face #(.COORD_BITS(COORD_BITS)) u_face_acd (
        .aclk    (aclk),
        .adv     (adv),
        .edge1_i (diff_reg[D_AC]),
        .edge2_i (diff_reg[D_AD]),
        .off_i   (diff_reg[D_AB]),
        .query_i (diff_reg[D_AQ]),
        .pass_o  (face_pass[2])
    );

    // Face opposite a: origin b, edges to c and d
    pit_face #(.COORD_BITS(COORD_BITS)) u_face_bcd (
        .aclk    (aclk),
        .adv     (adv),
        .edge1_i (diff_reg[D_BC]),
        .edge2_i (diff_reg[D_BD]),
        .off_i   (diff_reg[D_BA]),
        .query_i (diff_reg[D_BQ]),
        .pass_o  (face_pass[3])
    );

    // Hold the combined verdict in the output register
    always_ff @(posedge aclk) begin
        if (v3_reg && ready4) begin
            inside_reg <= &face_pass;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, inside_reg};

endmodule

[rtl/pit_face.sv]
// One face test: cross-product normal, two dot products, sign comparison.
module pit_face
    import pit_pkg::*;
#(
    parameter int unsigned COORD_BITS = 20
) (
    input  logic                          aclk,
    input  pit_adv_t                      adv,
    input  logic signed [COORD_BITS:0]    edge1_i [3],
    input  logic signed [COORD_BITS:0]    edge2_i [3],
    input  logic signed [COORD_BITS:0]    off_i   [3],
    input  logic signed [COORD_BITS:0]    query_i [3],
    output logic                          pass_o
);

    localparam int unsigned DW  = COORD_BITS + 1;       // edge component
    localparam int unsigned PW  = 2 * COORD_BITS + 2;   // cross partial product
    localparam int unsigned NW  = 2 * COORD_BITS + 3;   // normal component
    localparam int unsigned LW  = COORD_BITS + 2;       // low slice of a normal component
    localparam int unsigned LPW = DW + LW + 1;          // low dot partial product
    localparam int unsigned HPW = DW + NW - LW;         // high dot partial product
    localparam int unsigned SW  = 3 * COORD_BITS + 6;   // dot sum

    logic signed [NW-1:0]  normal_next [3];
    logic signed [NW-1:0]  normal_reg  [3];
    logic signed [DW-1:0]  off_reg     [3];
    logic signed [DW-1:0]  query_reg   [3];
    logic signed [LPW-1:0] off_lo_next   [3];
    logic signed [HPW-1:0] off_hi_next   [3];
    logic signed [LPW-1:0] query_lo_next [3];
    logic signed [HPW-1:0] query_hi_next [3];
    logic signed [LPW-1:0] off_lo_reg    [3];
    logic signed [HPW-1:0] off_hi_reg    [3];
    logic signed [LPW-1:0] query_lo_reg  [3];
    logic signed [HPW-1:0] query_hi_reg  [3];
    logic signed [SW-1:0]  off_hi_sum;
    logic signed [SW-1:0]  query_hi_sum;
    logic signed [SW-1:0]  off_sum;
    logic signed [SW-1:0]  query_sum;
    logic                  off_neg, off_pos, query_neg, query_pos;

    // Form the face normal as edge1 x edge2
    always_comb begin
        normal_next[0] = NW'(PW'(edge1_i[1]) * PW'(edge2_i[2]))
                       - NW'(PW'(edge1_i[2]) * PW'(edge2_i[1]));
        normal_next[1] = NW'(PW'(edge1_i[2]) * PW'(edge2_i[0]))
                       - NW'(PW'(edge1_i[0]) * PW'(edge2_i[2]));
        normal_next[2] = NW'(PW'(edge1_i[0]) * PW'(edge2_i[1]))
                       - NW'(PW'(edge1_i[1]) * PW'(edge2_i[0]));
    end

    always_ff @(posedge aclk) begin
        if (adv.adv2) begin
            normal_reg <= normal_next;
            off_reg    <= off_i;
            query_reg  <= query_i;
        end
    end

    // Multiply the off-face and query vectors by the signed high and
    // unsigned low slices of each normal component
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            off_lo_next[k]   = LPW'(off_reg[k])
                             * LPW'($signed({1'b0, normal_reg[k][LW-1:0]}));
            off_hi_next[k]   = HPW'(off_reg[k]) * HPW'($signed(normal_reg[k][NW-1:LW]));
            query_lo_next[k] = LPW'(query_reg[k])
                             * LPW'($signed({1'b0, normal_reg[k][LW-1:0]}));
            query_hi_next[k] = HPW'(query_reg[k]) * HPW'($signed(normal_reg[k][NW-1:LW]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.adv3) begin
            off_lo_reg   <= off_lo_next;
            off_hi_reg   <= off_hi_next;
            query_lo_reg <= query_lo_next;
            query_hi_reg <= query_hi_next;
        end
    end

    // Sum the terms and compare signs; a zero on either side passes
    always_comb begin
        off_hi_sum   = SW'(off_hi_reg[0]) + SW'(off_hi_reg[1]) + SW'(off_hi_reg[2]);
        query_hi_sum = SW'(query_hi_reg[0]) + SW'(query_hi_reg[1]) + SW'(query_hi_reg[2]);
        off_sum      = (off_hi_sum <<< LW) + SW'(off_lo_reg[0]) + SW'(off_lo_reg[1])
                     + SW'(off_lo_reg[2]);
        query_sum    = (query_hi_sum <<< LW) + SW'(query_lo_reg[0]) + SW'(query_lo_reg[1])
                     + SW'(query_lo_reg[2]);
        off_neg      = off_sum[SW-1];
        off_pos      = !off_sum[SW-1] && (off_sum != '0);
        query_neg    = query_sum[SW-1];
        query_pos    = !query_sum[SW-1] && (query_sum != '0);
        pass_o       = !((off_neg && query_pos) || (off_pos && query_neg));
    end

endmodule

[tb/sv/point_in_tetrahedron_test_tb.sv]
// Self-checking testbench for the point-in-tetrahedron orientation test block.
`timescale 1ns / 1ps

module point_in_tetrahedron_test_tb;
    import pit_pkg::*;

    localparam int CB          = 20;
    localparam int CMAX        = (1 << (CB - 1)) - 1;
    localparam int CMIN        = -(1 << (CB - 1));
    localparam int STALL_LIMIT = 1000;
    localparam int NUM_RANDOM  = 1100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN       = 8;

    typedef logic signed [127:0] wide_t;
    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } vec_t;
    typedef struct packed {
        logic [FIELD_W*NUM_POINTS-1:0] beat;
        logic                          known;
        logic                          hit;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // vertex_a, vertex_b, vertex_c, vertex_d, query_point, zero fill
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // is_inside, zero fill
    logic [M_TDATA_W-1:0] m_axis_tdata;

    bit   planned_inside[$];
    bit   inside_due[$];
    row_t dir_tab[$];
    int   err_count = 0;
    int   stall_cycles = 0;
    int   src_run = 0;
    bit   src_idle = 1'b0;

    point_in_tetrahedron_test #(.COORD_BITS(CB)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pack three signed coordinates, x lowest
    function automatic logic [FIELD_W-1:0] pt(int x, int y, int z);
        return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
    endfunction

    function automatic vec_t unpack_pt(logic [FIELD_W-1:0] f);
        vec_t v;
        v.x = longint'(signed'(f[CB-1:0]));
        v.y = longint'(signed'(f[2*CB-1:CB]));
        v.z = longint'(signed'(f[3*CB-1:2*CB]));
        return v;
    endfunction

    function automatic int dot_sign(vec_t u, vec_t n);
        wide_t s;
        s = wide_t'($signed(u.x)) * wide_t'($signed(n.x))
          + wide_t'($signed(u.y)) * wide_t'($signed(n.y))
          + wide_t'($signed(u.z)) * wide_t'($signed(n.z));
        return (s < 0) ? -1 : ((s > 0) ? 1 : 0);
    endfunction

    // One face: normal from the edges to e1 and e2 off the base, then compare sides
    function automatic bit face_holds(vec_t base, vec_t off, vec_t e1, vec_t e2, vec_t q);
        vec_t u;
        vec_t w;
        vec_t n;
        vec_t ro;
        vec_t rq;
        int   so;
        int   sq;
        u.x = e1.x - base.x;  u.y = e1.y - base.y;  u.z = e1.z - base.z;
        w.x = e2.x - base.x;  w.y = e2.y - base.y;  w.z = e2.z - base.z;
        n.x = u.y * w.z - u.z * w.y;
        n.y = u.z * w.x - u.x * w.z;
        n.z = u.x * w.y - u.y * w.x;
        ro.x = off.x - base.x;  ro.y = off.y - base.y;  ro.z = off.z - base.z;
        rq.x = q.x - base.x;    rq.y = q.y - base.y;    rq.z = q.z - base.z;
        so = dot_sign(ro, n);
        sq = dot_sign(rq, n);
        return !((so < 0 && sq > 0) || (so > 0 && sq < 0));
    endfunction

    function automatic bit predict_inside(logic [FIELD_W*NUM_POINTS-1:0] beat);
        vec_t a;
        vec_t b;
        vec_t c;
        vec_t d;
        vec_t q;
        a = unpack_pt(beat[PT_A*FIELD_W +: FIELD_W]);
        b = unpack_pt(beat[PT_B*FIELD_W +: FIELD_W]);
        c = unpack_pt(beat[PT_C*FIELD_W +: FIELD_W]);
        d = unpack_pt(beat[PT_D*FIELD_W +: FIELD_W]);
        q = unpack_pt(beat[PT_Q*FIELD_W +: FIELD_W]);
        return face_holds(a, d, b, c, q) && face_holds(a, c, b, d, q)
            && face_holds(a, b, c, d, q) && face_holds(b, a, c, d, q);
    endfunction

    // Split the stream into runs, each with random idle cycles or with none
    function automatic int draw_wait(inout int run_left, inout bit idle_on);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            idle_on  = ($urandom_range(0, 3) != 0);
        end
        run_left--;
        return idle_on ? int'($urandom_range(0, 11)) : 0;
    endfunction

    function automatic int gen_coord(int scale);
        case (scale)
            0:       return int'($urandom_range(0, (1 << CB) - 1)) + CMIN;
            1:       return int'($urandom_range(0, 16)) - 8;
            2:       return $urandom_range(0, 1) ? CMAX - int'($urandom_range(0, 3))
                                                 : CMIN + int'($urandom_range(0, 3));
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic add_row(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                           logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d,
                           logic [FIELD_W-1:0] q, bit known, bit hit);
        row_t r;
        r.beat  = {q, d, c, b, a};
        r.known = known;
        r.hit   = hit;
        dir_tab.push_back(r);
    endtask

    // Offer one beat after a random gap and hold it until accepted
    task automatic drive_beat(logic [FIELD_W*NUM_POINTS-1:0] beat, bit inside_exp);
        int wait_n;
        wait_n = draw_wait(src_run, src_idle);
        if (wait_n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (wait_n) @(posedge aclk);
        end
        planned_inside.push_back(inside_exp);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - FIELD_W*NUM_POINTS){1'b0}}, beat};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Stimulus: reset, directed table, then random tetrahedra and noise beats
    initial begin
        logic [FIELD_W*NUM_POINTS-1:0] beat;
        logic [319:0]                  raw;
        int                            vx[5][3];
        int                            scale;
        int                            i;
        int                            j;
        logic [FIELD_W-1:0]            o;
        logic [FIELD_W-1:0]            mn;
        logic [FIELD_W-1:0]            ex;
        logic [FIELD_W-1:0]            ey;
        logic [FIELD_W-1:0]            ez;

        o  = pt(0, 0, 0);
        mn = pt(CMIN, CMIN, CMIN);
        ex = pt(CMAX, CMIN, CMIN);
        ey = pt(CMIN, CMAX, CMIN);
        ez = pt(CMIN, CMIN, CMAX);
        // all vertices equal: fully degenerate, reported inside
        add_row(o, o, o, o, o, 1, 1);
        add_row({FIELD_W{1'b1}}, {FIELD_W{1'b1}}, {FIELD_W{1'b1}}, {FIELD_W{1'b1}},
                {FIELD_W{1'b1}}, 1, 1);
        add_row(pt(3, 3, 3), pt(3, 3, 3), pt(3, 3, 3), pt(3, 3, 3), pt(-9, 40, 7), 1, 1);
        // unit corner tetrahedron
        add_row(o, pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1), o, 1, 1);
        add_row(o, pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1), pt(1, 1, 1), 1, 0);
        add_row(o, pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1), pt(-1, 0, 0), 1, 0);
        // scaled corner: interior, on an edge, below the base, on a face
        add_row(o, pt(4, 0, 0), pt(0, 4, 0), pt(0, 0, 4), pt(1, 1, 1), 1, 1);
        add_row(o, pt(4, 0, 0), pt(0, 4, 0), pt(0, 0, 4), pt(2, 2, 0), 1, 1);
        add_row(o, pt(4, 0, 0), pt(0, 4, 0), pt(0, 0, 4), pt(0, 0, -1), 1, 0);
        add_row(o, pt(4, 0, 0), pt(0, 4, 0), pt(0, 0, 4), pt(1, 2, 1), 1, 1);
        // opposite vertex order
        add_row(o, pt(0, 4, 0), pt(4, 0, 0), pt(0, 0, 4), pt(1, 1, 1), 1, 1);
        add_row(o, pt(0, 4, 0), pt(4, 0, 0), pt(0, 0, 4), pt(3, 3, 3), 1, 0);
        // flat tetrahedron and collinear face: degenerate, reported inside
        add_row(o, pt(5, 0, 0), pt(0, 5, 0), pt(5, 5, 0), pt(0, 0, 7), 1, 1);
        add_row(o, pt(1, 0, 0), pt(2, 0, 0), pt(0, 0, 3), pt(0, 5, 0), 1, 1);
        // full-range extremes
        add_row(mn, ex, ey, ez, mn, 1, 1);
        add_row(mn, ex, ey, ez, ex, 1, 1);
        add_row(mn, ex, ey, ez, pt(CMAX, CMAX, CMAX), 1, 0);
        add_row(mn, ex, ey, ez, o, 1, 0);
        add_row(mn, ex, ey, ez, pt(CMIN + 1, CMIN + 1, CMIN + 1), 0, 0);
        add_row(pt(CMAX, CMAX, CMAX), pt(CMIN, CMAX, CMAX), pt(CMAX, CMIN, CMAX),
                pt(CMAX, CMAX, CMIN), pt(CMAX - 5, CMAX - 7, CMAX - 9), 0, 0);
        add_row(pt(CMAX, CMIN, CMAX), pt(CMIN, CMAX, CMIN), pt(CMAX, CMAX, CMIN),
                pt(CMIN, CMIN, CMAX), pt(-1, -1, -1), 0, 0);
        add_row(pt(-100, 250, -3), pt(700, -20, 9), pt(13, 900, -400),
                pt(-50, -60, 800), pt(100, 200, 50), 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[k])
            drive_beat(dir_tab[k].beat,
                       dir_tab[k].known ? dir_tab[k].hit : predict_inside(dir_tab[k].beat));

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any bit pattern
                for (int w = 0; w < 10; w++)
                    raw[w*32 +: 32] = $urandom;
                beat = raw[FIELD_W*NUM_POINTS-1:0];
            end else begin
                scale = $urandom_range(0, 3);
                for (int p = 0; p < 4; p++)
                    for (int k = 0; k < 3; k++)
                        vx[p][k] = gen_coord(scale);
                // sometimes flatten: d in the plane of a, b, c
                if ($urandom_range(0, 9) == 0)
                    for (int k = 0; k < 3; k++)
                        vx[PT_D][k] = vx[PT_B][k] + vx[PT_C][k] - vx[PT_A][k];
                i = $urandom_range(0, 3);
                j = $urandom_range(0, 3);
                case ($urandom_range(0, 4))
                    0: for (int k = 0; k < 3; k++) vx[PT_Q][k] = gen_coord(scale);
                    1: for (int k = 0; k < 3; k++)
                           vx[PT_Q][k] = (vx[0][k] + vx[1][k] + vx[2][k] + vx[3][k]) / 4
                                       + int'($urandom_range(0, 4)) - 2;
                    2: for (int k = 0; k < 3; k++) vx[PT_Q][k] = vx[i][k];
                    3: for (int k = 0; k < 3; k++) vx[PT_Q][k] = (vx[i][k] + vx[j][k]) / 2;
                    default: for (int k = 0; k < 3; k++)
                           vx[PT_Q][k] = (vx[0][k] + vx[1][k] + vx[2][k] + vx[3][k]) / 4;
                endcase
                for (int p = 0; p < 5; p++)
                    beat[p*FIELD_W +: FIELD_W] = pt(vx[p][0], vx[p][1], vx[p][2]);
            end
            drive_beat(beat, predict_inside(beat));
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (inside_due.size() != 0 || planned_inside.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side: random ready gaps, plus one long hold to back up the pipeline
    initial begin
        int wait_n;
        int got;
        int run_left;
        bit idle_on;
        bit held;
        got      = 0;
        run_left = 0;
        idle_on  = 1'b0;
        held     = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && got == HOLD_AT) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                wait_n = draw_wait(run_left, idle_on);
                if (wait_n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_n) @(posedge aclk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            got++;
        end
    end

    // Track accepted beats and check each result beat against the oldest one
    always @(posedge aclk) begin
        bit want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                inside_due.push_back(planned_inside.pop_front());
            if (m_axis_tvalid && m_axis_tready) begin
                if (inside_due.size() == 0) begin
                    $error("result beat with no query pending: is_inside=%0d",
                           m_axis_tdata[0]);
                    err_count++;
                end else begin
                    want = inside_due.pop_front();
                    if (m_axis_tdata[0] !== want) begin
                        $error("is_inside mismatch: expected %0d, actual %0d",
                               want, m_axis_tdata[0]);
                        err_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
